@@ hw/rtl/tbs_pkg.sv @@
package tbs_pkg;

    // Default values of the top-level parameters.
    localparam int TIME_BITS_DEF   = 48;
    localparam int LENGTH_BITS_DEF = 16;

    // Field widths fixed by the interface.
    localparam int TIME_FIELD_W   = 48;
    localparam int LENGTH_FIELD_W = 16;
    localparam int DEPTH_W        = 20;
    localparam int RATE_MBPS_W    = 17;
    localparam int TPS_W          = 32;
    localparam int TARGET_W       = 16;

    // Tokens per second is at most 131071 * 10^6, which fits in 37 bits.
    localparam int RATE_W = 37;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Step counter of the shared unit; the longest operation has RATE_W steps.
    localparam int CNT_W = 6;

    localparam int TOKENS_PER_MBIT = 1000000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TPS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd3;

    // Reset values. The rate is stored already scaled to tokens per second.
    localparam logic [RATE_W-1:0]   RATE_RESET    = 37'd1000000000;
    localparam logic [RATE_W-1:0]   RATE_M1_RESET = 37'd999999999;
    localparam logic [DEPTH_W-1:0]  DEPTH_RESET   = 20'd10000;
    localparam logic [TPS_W-1:0]    TPS_RESET     = 32'd2000000000;
    localparam logic [TARGET_W-1:0] TARGET_RESET  = 16'd0;

    // Operations of the shared arithmetic unit.
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;
    localparam logic [1:0] OP_ADD = 2'd2;

    typedef struct packed {
        logic [LENGTH_FIELD_W-1:0] packet_length;
        logic [TIME_FIELD_W-1:0]   arrival_time;
    } t_in;

    typedef struct packed {
        logic [TIME_FIELD_W-1:0] release_time;
        logic [DEPTH_W-1:0]      tokens_left;
        logic                    oversize;
        logic [TARGET_W-1:0]     destination_service;
    } t_out;

    typedef struct packed {
        logic [RATE_W-1:0]   rate;
        logic [RATE_W-1:0]   rate_m1;
        logic [TPS_W-1:0]    tps;
        logic [DEPTH_W-1:0]  depth;
        logic [TARGET_W-1:0] target;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [1:0]       op;
        logic [CNT_W-1:0] steps;
    } t_cmd;

endpackage

@@ hw/rtl/token_bucket_packet_shaper.sv @@
// Flow: an accepted packet is checked in S_CHECK; one covered by the stored tokens or longer
// than the bucket depth goes straight to S_DONE, while one that needs a refill first runs the
// shared unit (multiply, add, divide, multiply, and a divide unless >= 2^DEPTH_W tokens).
// Throughput: one packet at a time; the next beat is taken once the sequencer is back in
// S_IDLE, after the result is handed to the output register, which a stall can hold off.
// Reset is synchronous and active low: state registers, token level = depth, refill time = 0.
module token_bucket_packet_shaper #(
    parameter int TIME_BITS   = tbs_pkg::TIME_BITS_DEF,
    parameter int LENGTH_BITS = tbs_pkg::LENGTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tbs_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tbs_pkg::t_out                  o_out
);

    // All of the slow path runs through one shared add / shift unit:
    //   shortfall * tps          LENGTH_BITS multiply steps
    //   + (rate - 1)             one add step
    //   / rate                   LENGTH_BITS + 14 divide steps, gives the ticks needed
    //   elapsed * rate           RATE_W multiply steps
    //   / tps                    DEPTH_W divide steps, gives the tokens produced
    // The sum shortfall * tps + rate - 1 stays below 2^(LENGTH_BITS + 33) and the rate
    // is at least 10^6, so the quotient of the first division fits LENGTH_BITS + 14
    // bits. For the second division only values below the depth matter: when the
    // product shifted down by DEPTH_W bits already reaches tps, the refill saturates
    // and the division is skipped.
    localparam int ACC_W  = TIME_BITS + tbs_pkg::RATE_W;
    localparam int NEED_Q = LENGTH_BITS + 14;
    localparam int PROD_Q = tbs_pkg::DEPTH_W;
    localparam int Q_W    = (tbs_pkg::RATE_W > NEED_Q) ? tbs_pkg::RATE_W : NEED_Q;
    localparam int B_W    = (TIME_BITS > tbs_pkg::RATE_W) ? TIME_BITS : tbs_pkg::RATE_W;
    localparam int EXT_W  = 64;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] S_CHECK    = 4'd1;
    localparam logic [ST_W-1:0] S_WAIT_MS  = 4'd2;
    localparam logic [ST_W-1:0] S_WAIT_ADD = 4'd3;
    localparam logic [ST_W-1:0] S_WAIT_DN  = 4'd4;
    localparam logic [ST_W-1:0] S_PROD     = 4'd5;
    localparam logic [ST_W-1:0] S_WAIT_MP  = 4'd6;
    localparam logic [ST_W-1:0] S_WAIT_DP  = 4'd7;
    localparam logic [ST_W-1:0] S_DONE     = 4'd8;

    tbs_pkg::t_cfg r_cfg;
    logic          w_depth_wr;

    tbs_pkg::t_cmd    w_cmd;
    logic [ACC_W-1:0] w_acc_init;
    logic [Q_W-1:0]   w_q_init;
    logic [B_W-1:0]   w_b_init;
    logic             w_unit_busy;
    logic             w_unit_done;
    logic [ACC_W-1:0] w_unit_acc;
    logic [Q_W-1:0]   w_unit_q;

    // Sequencer and shaper state.
    logic [ST_W-1:0]             r_state,   n_state;
    logic [LENGTH_BITS-1:0]      r_len,     n_len;
    logic [TIME_BITS-1:0]        r_arr,     n_arr;
    logic [TIME_BITS-1:0]        r_last,    n_last;
    logic [tbs_pkg::DEPTH_W-1:0] r_level,   n_level;
    logic [TIME_BITS-1:0]        r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0]        r_rel,     n_rel;
    logic                        r_ovs,     n_ovs;
    logic                        r_out_valid, n_out_valid;
    tbs_pkg::t_out               r_out;
    logic                        w_load;

    logic                        w_accept;
    logic [EXT_W-1:0]            w_arr_ext;
    logic [tbs_pkg::DEPTH_W-1:0] w_len;
    logic [tbs_pkg::DEPTH_W-1:0] w_short;
    logic [TIME_BITS-1:0]        w_need;
    logic [ACC_W-1:0]            w_p_hi;
    logic                        w_full;
    logic [tbs_pkg::DEPTH_W-1:0] w_prod;
    logic [tbs_pkg::DEPTH_W-1:0] w_room;
    logic [EXT_W-1:0]            w_rel_ext;

    tbs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (r_cfg),
        .o_depth_wr (w_depth_wr)
    );

    tbs_unit #(
        .ACC_W (ACC_W),
        .Q_W   (Q_W),
        .B_W   (B_W)
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_acc   (w_acc_init),
        .i_q     (w_q_init),
        .i_b     (w_b_init),
        .o_busy  (w_unit_busy),
        .o_done  (w_unit_done),
        .o_acc   (w_unit_acc),
        .o_q     (w_unit_q)
    );

    // Input beats are taken only while the sequencer is idle. A finished result
    // may still sit in the output register at that time.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        // Arrival time is taken in its low TIME_BITS bits.
        w_arr_ext = EXT_W'(i_in.arrival_time);
        w_len     = tbs_pkg::DEPTH_W'(r_len);
        w_short   = w_len - r_level;
        w_need    = TIME_BITS'(w_unit_q[NEED_Q-1:0]);
        w_p_hi    = w_unit_acc >> PROD_Q;
        w_full    = (w_p_hi >= ACC_W'(r_cfg.tps));
        w_prod    = w_unit_q[PROD_Q-1:0];
        w_room    = r_cfg.depth - r_level;

        n_state   = r_state;
        n_len     = r_len;
        n_arr     = r_arr;
        n_last    = r_last;
        n_level   = r_level;
        n_elapsed = r_elapsed;
        n_rel     = r_rel;
        n_ovs     = r_ovs;
        w_load    = 1'b0;

        w_cmd      = '0;
        w_acc_init = '0;
        w_q_init   = '0;
        w_b_init   = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_len   = i_in.packet_length[LENGTH_BITS-1:0];
                    n_arr   = w_arr_ext[TIME_BITS-1:0];
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // Ticks since the last refill, modulo the time width.
                n_elapsed = r_arr - r_last;
                n_ovs     = 1'b0;
                if (w_len > r_cfg.depth) begin
                    // A packet longer than the bucket is flagged and changes nothing.
                    n_rel   = r_arr;
                    n_ovs   = 1'b1;
                    n_state = S_DONE;
                end else if (r_level >= w_len) begin
                    // Enough tokens on hand: leave at once, no refill, no time update.
                    n_level = r_level - w_len;
                    n_rel   = r_arr;
                    n_state = S_DONE;
                end else begin
                    w_cmd.start = 1'b1;
                    w_cmd.op    = tbs_pkg::OP_MUL;
                    w_cmd.steps = tbs_pkg::CNT_W'(LENGTH_BITS);
                    w_q_init    = Q_W'(w_short[LENGTH_BITS-1:0]) << (Q_W - LENGTH_BITS);
                    w_b_init    = B_W'(r_cfg.tps);
                    n_state     = S_WAIT_MS;
                end
            end
            S_WAIT_MS: begin
                // Round the tick count up by adding rate - 1 before dividing.
                if (w_unit_done) begin
                    w_cmd.start = 1'b1;
                    w_cmd.op    = tbs_pkg::OP_ADD;
                    w_cmd.steps = tbs_pkg::CNT_W'(1);
                    w_acc_init  = w_unit_acc;
                    w_b_init    = B_W'(r_cfg.rate_m1);
                    n_state     = S_WAIT_ADD;
                end
            end
            S_WAIT_ADD: begin
                if (w_unit_done) begin
                    w_cmd.start = 1'b1;
                    w_cmd.op    = tbs_pkg::OP_DIV;
                    w_cmd.steps = tbs_pkg::CNT_W'(NEED_Q);
                    w_acc_init  = w_unit_acc >> NEED_Q;
                    w_q_init    = Q_W'(w_unit_acc[NEED_Q-1:0]) << (Q_W - NEED_Q);
                    w_b_init    = B_W'(r_cfg.rate);
                    n_state     = S_WAIT_DN;
                end
            end
            S_WAIT_DN: begin
                // If too few ticks have gone by, the packet waits until the
                // shortfall is produced and the refill covers exactly that span.
                if (w_unit_done) begin
                    if (r_elapsed < w_need) begin
                        n_elapsed = w_need;
                        n_rel     = r_last + w_need;
                    end else begin
                        n_rel = r_arr;
                    end
                    n_state = S_PROD;
                end
            end
            S_PROD: begin
                w_cmd.start = 1'b1;
                w_cmd.op    = tbs_pkg::OP_MUL;
                w_cmd.steps = tbs_pkg::CNT_W'(tbs_pkg::RATE_W);
                w_q_init    = Q_W'(r_cfg.rate) << (Q_W - tbs_pkg::RATE_W);
                w_b_init    = B_W'(r_elapsed);
                n_state     = S_WAIT_MP;
            end
            S_WAIT_MP: begin
                if (w_unit_done) begin
                    if (w_full) begin
                        // At least 2^DEPTH_W tokens produced: the bucket fills up.
                        n_level = r_cfg.depth - w_len;
                        n_last  = r_rel;
                        n_state = S_DONE;
                    end else begin
                        w_cmd.start = 1'b1;
                        w_cmd.op    = tbs_pkg::OP_DIV;
                        w_cmd.steps = tbs_pkg::CNT_W'(PROD_Q);
                        w_acc_init  = w_p_hi;
                        w_q_init    = Q_W'(w_unit_acc[PROD_Q-1:0]) << (Q_W - PROD_Q);
                        w_b_init    = B_W'(r_cfg.tps);
                        n_state     = S_WAIT_DP;
                    end
                end
            end
            S_WAIT_DP: begin
                if (w_unit_done) begin
                    if (w_prod >= w_room) begin
                        n_level = r_cfg.depth - w_len;
                    end else begin
                        n_level = r_level + w_prod - w_len;
                    end
                    n_last  = r_rel;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free or drains
                // in this very cycle.
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A depth write also refills the bucket. User writes only while idle; not enforced.
        if (w_depth_wr) begin
            n_level = i_cfg_data[tbs_pkg::DEPTH_W-1:0];
        end

        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        w_rel_ext = EXT_W'(r_rel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= tbs_pkg::DEPTH_RESET;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Per-packet working registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_arr     <= n_arr;
        r_elapsed <= n_elapsed;
        r_rel     <= n_rel;
        r_ovs     <= n_ovs;
        if (w_load) begin
            r_out.release_time        <= w_rel_ext[tbs_pkg::TIME_FIELD_W-1:0];
            r_out.tokens_left         <= r_level;
            r_out.oversize            <= r_ovs;
            r_out.destination_service <= r_cfg.target;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> !w_unit_busy)
        else $error("shared unit started while still running");

    a_level_in_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= r_cfg.depth)
        else $error("token level above the bucket depth");

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CHECK))
        else $error("accepted beat did not start a check");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared without a finished packet");

endmodule

@@ hw/rtl/tbs_cfg.sv @@
module tbs_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output tbs_pkg::t_cfg                      o_cfg,
    output logic                               o_depth_wr
);

    logic [tbs_pkg::RATE_MBPS_W-1:0] w_mbps;
    logic [tbs_pkg::RATE_W-1:0]      w_rate;
    logic [tbs_pkg::TPS_W-1:0]       w_tps;

    logic [tbs_pkg::RATE_W-1:0]   r_rate;
    logic [tbs_pkg::RATE_W-1:0]   r_rate_m1;
    logic [tbs_pkg::TPS_W-1:0]    r_tps;
    logic [tbs_pkg::DEPTH_W-1:0]  r_depth;
    logic [tbs_pkg::TARGET_W-1:0] r_target;

    // A zero rate or a zero tick frequency is taken as one.
    always_comb begin
        w_mbps = i_cfg_data[tbs_pkg::RATE_MBPS_W-1:0];
        if (w_mbps == '0) begin
            w_mbps = tbs_pkg::RATE_MBPS_W'(1);
        end
        w_rate = tbs_pkg::RATE_W'(w_mbps) * tbs_pkg::RATE_W'(tbs_pkg::TOKENS_PER_MBIT);
        w_tps  = i_cfg_data[tbs_pkg::TPS_W-1:0];
        if (w_tps == '0) begin
            w_tps = tbs_pkg::TPS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= tbs_pkg::RATE_RESET;
            r_rate_m1 <= tbs_pkg::RATE_M1_RESET;
            r_tps     <= tbs_pkg::TPS_RESET;
            r_depth   <= tbs_pkg::DEPTH_RESET;
            r_target  <= tbs_pkg::TARGET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbs_pkg::REG_RATE: begin
                    r_rate    <= w_rate;
                    r_rate_m1 <= w_rate - tbs_pkg::RATE_W'(1);
                end
                tbs_pkg::REG_DEPTH: begin
                    r_depth <= i_cfg_data[tbs_pkg::DEPTH_W-1:0];
                end
                tbs_pkg::REG_TPS: begin
                    r_tps <= w_tps;
                end
                tbs_pkg::REG_TARGET: begin
                    r_target <= i_cfg_data[tbs_pkg::TARGET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.rate    = r_rate;
    assign o_cfg.rate_m1 = r_rate_m1;
    assign o_cfg.tps     = r_tps;
    assign o_cfg.depth   = r_depth;
    assign o_cfg.target  = r_target;
    assign o_depth_wr    = i_cfg_we && (i_cfg_idx == tbs_pkg::REG_DEPTH);

endmodule

@@ hw/rtl/tbs_unit.sv @@
module tbs_unit #(
    parameter int ACC_W = tbs_pkg::TIME_BITS_DEF + tbs_pkg::RATE_W,
    parameter int Q_W   = tbs_pkg::RATE_W,
    parameter int B_W   = tbs_pkg::TIME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tbs_pkg::t_cmd    i_cmd,
    input  logic [ACC_W-1:0] i_acc,
    input  logic [Q_W-1:0]   i_q,
    input  logic [B_W-1:0]   i_b,
    output logic             o_busy,
    output logic             o_done,
    output logic [ACC_W-1:0] o_acc,
    output logic [Q_W-1:0]   o_q
);

    logic                      r_busy;
    logic                      r_done;
    logic [tbs_pkg::CNT_W-1:0] r_cnt;
    logic [1:0]                r_op;
    logic [ACC_W-1:0]          r_acc;
    logic [Q_W-1:0]            r_q;
    logic [B_W-1:0]            r_b;

    logic [ACC_W-1:0] w_bext;
    logic [ACC_W-1:0] w_sh;
    logic [ACC_W-1:0] w_addend;
    logic             w_cin;
    logic [ACC_W:0]   w_sum;
    logic [ACC_W-1:0] n_acc;
    logic [Q_W-1:0]   n_q;

    // One adder serves every operation. A multiply step shifts the product
    // left and adds the multiplicand when the top multiplier bit is set. A
    // divide step shifts the next dividend bit into the remainder and keeps
    // the difference when it does not borrow.
    always_comb begin
        w_bext   = ACC_W'(r_b);
        w_sh     = r_acc;
        w_addend = '0;
        w_cin    = 1'b0;
        case (r_op)
            tbs_pkg::OP_MUL: begin
                w_sh     = {r_acc[ACC_W-2:0], 1'b0};
                w_addend = r_q[Q_W-1] ? w_bext : '0;
            end
            tbs_pkg::OP_DIV: begin
                w_sh     = {r_acc[ACC_W-2:0], r_q[Q_W-1]};
                w_addend = ~w_bext;
                w_cin    = 1'b1;
            end
            tbs_pkg::OP_ADD: begin
                w_addend = w_bext;
            end
            default: begin
            end
        endcase
        w_sum = {1'b0, w_sh} + {1'b0, w_addend} + (ACC_W + 1)'(w_cin);

        n_acc = w_sum[ACC_W-1:0];
        n_q   = r_q;
        case (r_op)
            tbs_pkg::OP_MUL: begin
                n_q = {r_q[Q_W-2:0], 1'b0};
            end
            tbs_pkg::OP_DIV: begin
                n_acc = w_sum[ACC_W] ? w_sum[ACC_W-1:0] : w_sh;
                n_q   = {r_q[Q_W-2:0], w_sum[ACC_W]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - tbs_pkg::CNT_W'(1);
                if (r_cnt == tbs_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_acc <= i_acc;
            r_q   <= i_q;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_q   <= n_q;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_acc  = r_acc;
    assign o_q    = r_q;

    a_busy_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("unit busy with an empty step count");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("unit done without a running operation");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("unit done held longer than one cycle");

endmodule

@@ tb/token_bucket_packet_shaper_test.sv @@
`timescale 1ns / 100ps

module token_bucket_packet_shaper_test;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [31:0]   i_cfg_data;
    logic          i_in_valid;
    logic          o_in_stall;
    tbs_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_stall;
    tbs_pkg::t_out o_out;

    token_bucket_packet_shaper u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the registers and of the bucket state, at reset values.
    logic [16:0] rate_cfg    = 17'd1000;
    logic [19:0] depth_cfg   = 20'd10000;
    logic [31:0] tps_cfg     = 32'd2000000000;
    logic [15:0] target_cfg  = 16'd0;
    logic [19:0] level       = 20'd10000;
    logic [47:0] last_refill = 48'd0;

    tbs_pkg::t_out shaped_q[$];
    tbs_pkg::t_out head_beat;
    int            mismatches = 0;

    // Idling controls; each phase of the run picks its own.
    bit   in_idle_en  = 1'b0;
    bit   out_idle_en = 1'b0;
    int   stall_left  = 0;

    // Works out the beat the shaper should produce for one packet and
    // advances the shadow bucket state.
    function automatic tbs_pkg::t_out shape_packet(input tbs_pkg::t_in pkt);
        tbs_pkg::t_out res;
        logic [63:0]   len;
        logic [63:0]   rate_tps;
        logic [63:0]   tps_eff;
        logic [63:0]   need;
        logic [63:0]   elapsed;
        logic [47:0]   gap48;
        logic [47:0]   release_t;
        logic [127:0]  produced;
        len = 64'(pkt.packet_length);
        release_t = pkt.arrival_time;
        res.oversize = 1'b0;
        if (len > 64'(depth_cfg)) begin
            res.oversize = 1'b1;
        end else if (64'(level) >= len) begin
            level = level - len[19:0];
        end else begin
            rate_tps = ((rate_cfg == 17'd0) ? 64'd1 : 64'(rate_cfg)) *
                       64'(tbs_pkg::TOKENS_PER_MBIT);
            tps_eff = (tps_cfg == 32'd0) ? 64'd1 : 64'(tps_cfg);
            need = ((len - 64'(level)) * tps_eff + rate_tps - 64'd1) / rate_tps;
            // Elapsed ticks wrap at the timestamp width.
            gap48 = pkt.arrival_time - last_refill;
            elapsed = 64'(gap48);
            if (elapsed < need) begin
                elapsed = need;
                release_t = last_refill + need[47:0];
            end
            produced = (128'(elapsed) * 128'(rate_tps)) / 128'(tps_eff);
            if (produced >= 128'(depth_cfg - level)) begin
                level = depth_cfg;
            end else begin
                level = level + produced[19:0];
            end
            level = level - len[19:0];
            last_refill = release_t;
        end
        res.release_time = release_t;
        res.tokens_left = level;
        res.destination_service = target_cfg;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!in_idle_en || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    task automatic send_packet(input logic [15:0] len, input logic [47:0] at);
        tbs_pkg::t_in pkt;
        int           gap;
        pkt.packet_length = len;
        pkt.arrival_time = at;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            i_in = tbs_pkg::t_in'({$urandom, $urandom});
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in = pkt;
        do @(posedge i_clk); while (o_in_stall);
        shaped_q.push_back(shape_packet(pkt));
    endtask

    // Lowers valid and waits until every predicted beat has come out.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (shaped_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            tbs_pkg::REG_RATE: begin
                rate_cfg = data[tbs_pkg::RATE_MBPS_W-1:0];
            end
            tbs_pkg::REG_DEPTH: begin
                depth_cfg = data[tbs_pkg::DEPTH_W-1:0];
                level = data[tbs_pkg::DEPTH_W-1:0];
            end
            tbs_pkg::REG_TPS: begin
                tps_cfg = data;
            end
            default: begin
                target_cfg = data[tbs_pkg::TARGET_W-1:0];
            end
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Random settings that lean on the extremes; unused upper data bits
    // are sometimes set to show they are ignored.
    task automatic pick_config();
        logic [31:0] v;
        int          r;
        r = $urandom_range(0, 9);
        v = (r == 0) ? 32'd0 : (r == 1) ? 32'd131071 : (r == 2) ? 32'd1 :
            32'($urandom_range(1, 100000));
        if ($urandom_range(0, 3) == 0) begin
            v = v | ($urandom << tbs_pkg::RATE_MBPS_W);
        end
        write_reg(tbs_pkg::REG_RATE, v);
        r = $urandom_range(0, 9);
        v = (r == 0) ? 32'd0 : (r == 1) ? 32'd1048575 :
            (r == 2) ? 32'($urandom_range(1, 100)) : 32'($urandom_range(1000, 200000));
        if ($urandom_range(0, 3) == 0) begin
            v = v | ($urandom << tbs_pkg::DEPTH_W);
        end
        write_reg(tbs_pkg::REG_DEPTH, v);
        r = $urandom_range(0, 9);
        v = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? 32'd1 :
            (r == 3) ? 32'($urandom_range(1000, 1000000)) :
            32'($urandom_range(100000000, 32'd3000000000));
        write_reg(tbs_pkg::REG_TPS, v);
        write_reg(tbs_pkg::REG_TARGET, $urandom);
    endtask

    // Default settings: covered packets, refills, oversize packets and
    // arrivals that run backward or across the top of the tick counter.
    task automatic test_bucket_basics();
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
        send_packet(16'd0, 48'd0);
        send_packet(16'd10000, 48'd0);
        send_packet(16'd1, 48'd0);
        send_packet(16'd10001, 48'd50);
        send_packet(16'd65535, 48'd60);
        send_packet(16'd5000, 48'd1000);
        send_packet(16'd3000, 48'd100000);
        send_packet(16'd7000, 48'd100000);
        send_packet(16'd200, 48'd90);
        send_packet(16'd10000, 48'hFFFF_FFFF_FFFF);
        // The release tick wraps past zero here.
        send_packet(16'd2, 48'd0);
        drain();
    endtask

    // Zero rate and zero frequency, the largest values, the smallest
    // depths and a refill product far past 64 bits.
    task automatic test_register_extremes();
        write_reg(tbs_pkg::REG_RATE, 32'd0);
        write_reg(tbs_pkg::REG_TPS, 32'd0);
        write_reg(tbs_pkg::REG_DEPTH, 32'd65535);
        write_reg(tbs_pkg::REG_TARGET, 32'hABCD_FFFF);
        send_packet(16'd65535, 48'd10);
        send_packet(16'd65535, 48'd10);
        drain();
        write_reg(tbs_pkg::REG_RATE, 32'd131071);
        write_reg(tbs_pkg::REG_TPS, 32'd1);
        write_reg(tbs_pkg::REG_DEPTH, 32'hFFF0_0000 | 32'd1048575);
        send_packet(16'd65535, 48'd20);
        send_packet(16'd65535, 48'hFFFF_0000_0000);
        drain();
        write_reg(tbs_pkg::REG_RATE, 32'hFFFE_0001);
        write_reg(tbs_pkg::REG_TPS, 32'hFFFF_FFFF);
        write_reg(tbs_pkg::REG_DEPTH, 32'd0);
        write_reg(tbs_pkg::REG_TARGET, 32'd0);
        send_packet(16'd0, 48'hFFFF_0000_0010);
        send_packet(16'd1, 48'hFFFF_0000_0010);
        drain();
        write_reg(tbs_pkg::REG_DEPTH, 32'd1);
        send_packet(16'd1, 48'hFFFF_0000_0020);
        send_packet(16'd1, 48'hFFFF_0000_0030);
        send_packet(16'd1, 48'hFFFF_FFFF_FF00);
        drain();
    endtask

    // Mostly packet sizes within the bucket and arrival spacing near the
    // refill time, so both the covered and the waiting paths are taken;
    // a few oversize packets, backward steps and huge jumps are mixed in.
    task automatic test_random_traffic(input int phases, input int per_phase);
        logic [47:0] cursor;
        logic [63:0] ticks;
        logic [63:0] span;
        logic [15:0] len;
        int          lim;
        int          r;
        cursor = 48'($urandom);
        for (int p = 0; p < phases; p++) begin
            pick_config();
            r = $urandom_range(0, 3);
            in_idle_en = r[0];
            out_idle_en = r[1];
            for (int k = 0; k < per_phase; k++) begin
                lim = (depth_cfg > 20'd65535) ? 65535 : int'(depth_cfg);
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    len = 16'($urandom);
                end else if (r < 40) begin
                    len = 16'($urandom_range(0, lim / 8));
                end else begin
                    len = 16'($urandom_range(0, lim));
                end
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    cursor = cursor - 48'($urandom);
                end else if (r < 8) begin
                    cursor = cursor + 48'({$urandom, $urandom});
                end else begin
                    ticks = (64'(len) * ((tps_cfg == 32'd0) ? 64'd1 : 64'(tps_cfg))) /
                            (((rate_cfg == 17'd0) ? 64'd1 : 64'(rate_cfg)) *
                             64'(tbs_pkg::TOKENS_PER_MBIT));
                    span = 64'd2 * ticks + 64'd3;
                    cursor = cursor + 48'({$urandom, $urandom} % span);
                end
                send_packet(len, cursor);
            end
            drain();
        end
    endtask

    // Output side: stall bursts, mostly short with a few long ones.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall = 1'b0;
            if (out_idle_en && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) :
                             $urandom_range(8, 40);
            end
        end
    end

    // Every beat taken from the shaper is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (shaped_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected beat: release %0d tokens %0d",
                             $time, o_out.release_time, o_out.tokens_left);
                    $display("    oversize %0b dest %0d",
                             o_out.oversize, o_out.destination_service);
                end
            end else begin
                head_beat = shaped_q.pop_front();
                if (o_out.release_time !== head_beat.release_time ||
                    o_out.tokens_left !== head_beat.tokens_left ||
                    o_out.oversize !== head_beat.oversize ||
                    o_out.destination_service !== head_beat.destination_service) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected/actual release %0d/%0d tokens %0d/%0d",
                                 $time, head_beat.release_time, o_out.release_time,
                                 head_beat.tokens_left, o_out.tokens_left);
                        $display("    oversize %0b/%0b dest %0d/%0d",
                                 head_beat.oversize, o_out.oversize,
                                 head_beat.destination_service,
                                 o_out.destination_service);
                    end
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tbs_pkg::REG_RATE;
        i_cfg_data = 32'd0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_bucket_basics();
        test_register_extremes();
        test_random_traffic(10, 175);

        drain();
        repeat (150) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
